// File: sv/wrp_pkg.sv
// wrp_pkg: shared types and constants of the wav riff chunk parser
// no dependencies; used by wrp_core and wav_riff_chunk_parser
`default_nettype none

package wrp_pkg;

  // default minimum file size in bytes
  localparam int unsigned MIN_FILE_BYTES_DEF = 44;

  // chunk and header tags as they sit in the shift register (little-endian)
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // fmt chunk checks
  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [15:0] FMT_PCM     = 16'd1;
  localparam logic [15:0] FMT_FLOAT   = 16'd3;

  // report codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INVALID     = 2'd1,
    ST_UNSUPPORTED = 2'd2
  } status_t;

  // one result item
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        report_valid;
    status_t     status;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
  } result_t;

endpackage

`default_nettype wire

// File: sv/wrp_core.sv
// wrp_core: per-byte parse state and next-state logic of the wav parser
// depends on wrp_pkg; result is combinational on the accepted item
`default_nettype none

module wrp_core #(
  parameter int unsigned MIN_FILE_BYTES = wrp_pkg::MIN_FILE_BYTES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            take,
  input  wire logic [7:0]      in_byte,
  input  wire logic [31:0]     file_length,
  output logic                 res_valid,
  output wrp_pkg::result_t     res
);
  import wrp_pkg::*;

  typedef enum logic [3:0] {
    PH_HEAD,
    PH_ID,
    PH_SZ_FMT,
    PH_SZ_DATA,
    PH_SZ_OTHER,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_PAD
  } phase_t;

  localparam logic [32:0] POS_RIFF_LAST = 33'd3;
  localparam logic [32:0] POS_WAVE_LAST = 33'd11;
  localparam logic [32:0] HDR_BYTES     = 33'd8;
  localparam logic [32:0] SIZE_BYTES    = 33'd4;
  localparam logic [32:0] OFF_FORMAT    = 33'd1;
  localparam logic [32:0] OFF_CHANNELS  = 33'd3;
  localparam logic [32:0] OFF_RATE      = 33'd7;
  localparam logic [32:0] OFF_BITS      = 33'd15;

  logic [32:0] pos_r, pos_nxt;
  phase_t      phase_r, phase_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] len_r, len_nxt;
  logic [32:0] end_r, end_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic        done_r, done_nxt;

  logic [32:0] nxt_pos;
  logic [32:0] file_len33;
  logic [31:0] shifted;
  logic [32:0] end_new;
  logic [32:0] body_off;
  logic        report;
  logic        pay;
  status_t     status;

  // next state for one accepted byte
  always_comb begin
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    shift_nxt    = shift_r;
    len_nxt      = len_r;
    end_nxt      = end_r;
    fmt_seen_nxt = fmt_seen_r;
    chan_nxt     = chan_r;
    rate_nxt     = rate_r;
    bits_nxt     = bits_r;
    done_nxt     = done_r;
    report       = 1'b0;
    pay          = 1'b0;
    status       = ST_OK;

    nxt_pos    = pos_r + 33'd1;
    file_len33 = {1'b0, file_length};
    shifted    = {in_byte, shift_r[31:8]};
    end_new    = nxt_pos + {1'b0, shifted};
    body_off   = pos_r + {1'b0, len_r} - end_r;

    if (take) begin
      // position saturates at 2^32
      if (!pos_r[32]) begin
        pos_nxt = nxt_pos;
      end
      if (!done_r) begin
        if (pos_r >= file_len33) begin
          report = 1'b1;
          status = ST_INVALID;
        end else if (pos_r == 33'd0 && file_length < 32'(MIN_FILE_BYTES)) begin
          report = 1'b1;
          status = ST_INVALID;
        end else begin
          shift_nxt = shifted;
          case (phase_r)
            PH_HEAD: begin
              if (pos_r == POS_RIFF_LAST && shifted != TAG_RIFF) begin
                report = 1'b1;
                status = ST_INVALID;
              end else if (pos_r == POS_WAVE_LAST) begin
                if (shifted != TAG_WAVE) begin
                  report = 1'b1;
                  status = ST_INVALID;
                end else begin
                  phase_nxt = PH_ID;
                  end_nxt   = nxt_pos + HDR_BYTES;
                end
              end
            end
            PH_ID: begin
              if (nxt_pos + SIZE_BYTES == end_r) begin
                if (shifted == TAG_FMT) begin
                  phase_nxt = PH_SZ_FMT;
                end else if (shifted == TAG_DATA) begin
                  phase_nxt = PH_SZ_DATA;
                end else begin
                  phase_nxt = PH_SZ_OTHER;
                end
              end
            end
            PH_SZ_FMT: begin
              if (nxt_pos == end_r) begin
                len_nxt = shifted;
                if (shifted < FMT_MIN_LEN || end_new > file_len33) begin
                  report = 1'b1;
                  status = ST_INVALID;
                end else begin
                  end_nxt   = end_new;
                  phase_nxt = PH_FMT;
                end
              end
            end
            PH_SZ_DATA: begin
              if (nxt_pos == end_r) begin
                len_nxt = shifted;
                if (!fmt_seen_r) begin
                  report = 1'b1;
                  status = ST_INVALID;
                end else begin
                  // cut a truncated data chunk at file end
                  end_nxt = (end_new > file_len33) ? file_len33 : end_new;
                  if (end_nxt <= nxt_pos) begin
                    report = 1'b1;
                    status = ST_OK;
                  end else begin
                    phase_nxt = PH_DATA;
                  end
                end
              end
            end
            PH_SZ_OTHER: begin
              if (nxt_pos == end_r) begin
                len_nxt = shifted;
                end_nxt = end_new;
                if (shifted == 32'd0) begin
                  phase_nxt = PH_ID;
                  end_nxt   = nxt_pos + HDR_BYTES;
                end else begin
                  phase_nxt = PH_SKIP;
                end
              end
            end
            PH_FMT: begin
              // pick fields by offset into the chunk body
              if (body_off == OFF_FORMAT) begin
                if (!(shifted[31:16] inside {FMT_PCM, FMT_FLOAT})) begin
                  report = 1'b1;
                  status = ST_UNSUPPORTED;
                end
              end else if (body_off == OFF_CHANNELS) begin
                chan_nxt = shifted[31:16];
              end else if (body_off == OFF_RATE) begin
                rate_nxt = shifted;
              end else if (body_off == OFF_BITS) begin
                bits_nxt = shifted[31:16];
              end
              if (!report && nxt_pos == end_r) begin
                fmt_seen_nxt = 1'b1;
                if (len_r[0]) begin
                  phase_nxt = PH_PAD;
                end else begin
                  phase_nxt = PH_ID;
                  end_nxt   = nxt_pos + HDR_BYTES;
                end
              end
            end
            PH_SKIP: begin
              if (nxt_pos == end_r) begin
                if (len_r[0]) begin
                  phase_nxt = PH_PAD;
                end else begin
                  phase_nxt = PH_ID;
                  end_nxt   = nxt_pos + HDR_BYTES;
                end
              end
            end
            PH_DATA: begin
              pay = 1'b1;
              if (nxt_pos >= end_r) begin
                report = 1'b1;
                status = ST_OK;
              end
            end
            PH_PAD: begin
              phase_nxt = PH_ID;
              end_nxt   = nxt_pos + HDR_BYTES;
            end
            default: begin
              report = 1'b1;
              status = ST_INVALID;
            end
          endcase
          // last file byte with nothing reported yet
          if (!report && nxt_pos == file_len33) begin
            report = 1'b1;
            status = ST_INVALID;
          end
        end
        if (report) begin
          done_nxt = 1'b1;
        end
      end
    end
  end

  // result item for this byte
  always_comb begin
    res_valid         = report | pay;
    res.payload_byte  = pay ? in_byte : 8'd0;
    res.payload_valid = pay;
    res.report_valid  = report;
    res.status        = report ? status : ST_OK;
    res.channel_count = chan_nxt;
    res.rate_hz       = rate_nxt;
    res.sample_bits   = bits_nxt;
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      phase_r    <= PH_HEAD;
      shift_r    <= '0;
      len_r      <= '0;
      end_r      <= '0;
      fmt_seen_r <= 1'b0;
      chan_r     <= '0;
      rate_r     <= '0;
      bits_r     <= '0;
      done_r     <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      phase_r    <= phase_nxt;
      shift_r    <= shift_nxt;
      len_r      <= len_nxt;
      end_r      <= end_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      chan_r     <= chan_nxt;
      rate_r     <= rate_nxt;
      bits_r     <= bits_nxt;
      done_r     <= done_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/wav_riff_chunk_parser.sv
// wav_riff_chunk_parser: byte-serial wav header walker and data payload pass-through
// one byte accepted per cycle unless in_stall; results are registered at the output
// in_stall rises only while the output register and the skid register both hold items
// reset (rst_n low, synchronous) clears file_length, the parse state and both valid flags
// depends on wrp_pkg and wrp_core
`default_nettype none

module wav_riff_chunk_parser #(
  parameter int unsigned MIN_FILE_BYTES = wrp_pkg::MIN_FILE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  // result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_payload_byte,
  output logic             out_payload_valid,
  output logic             out_report_valid,
  output logic [1:0]       out_status,
  output logic [15:0]      out_channel_count,
  output logic [31:0]      out_rate_hz,
  output logic [15:0]      out_sample_bits
);
  import wrp_pkg::*;

  logic [31:0] file_length_r;
  logic        take;
  logic        res_valid;
  result_t     res;
  logic        out_valid_r;
  result_t     out_res_r;
  logic        skid_valid_r;
  result_t     skid_res_r;
  logic        slot_free;

  // file length register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      file_length_r <= cfg_data;
    end
  end

  // parse core
  assign in_stall = skid_valid_r;
  assign take     = in_valid && !in_stall;

  wrp_core #(
    .MIN_FILE_BYTES(MIN_FILE_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .in_byte    (in_byte),
    .file_length(file_length_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register with skid behind it
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_res_r <= skid_valid_r ? skid_res_r : res;
    end else if (res_valid) begin
      skid_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = out_res_r.payload_byte;
  assign out_payload_valid = out_res_r.payload_valid;
  assign out_report_valid  = out_res_r.report_valid;
  assign out_status        = out_res_r.status;
  assign out_channel_count = out_res_r.channel_count;
  assign out_rate_hz       = out_res_r.rate_hz;
  assign out_sample_bits   = out_res_r.sample_bits;

`ifndef SYNTHESIS
  // skid only fills behind a held output item
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item with the output register empty");

  // a report ends the parse: the next byte gives no result
  a_single_report: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.report_valid) |=> !res_valid)
    else $error("result produced after the report");

  // a nonzero status only rides on a report
  a_status_with_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_report_valid || out_status == ST_OK))
    else $error("status set on a non-report item");
`endif

endmodule

`default_nettype wire
